// ----- src/pic_pkg.sv -----
// Shared types and constants of the prioritized interrupt controller.
// Used by pic_ctrl, pic_datapath and the top level; no dependencies.
package pic_pkg;

	localparam int PIC_NUM_IRQ = 896;
	localparam int PIC_NUM_CPU = 8;

	// request kinds
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_LINE  = 2'd2;

	// register map
	localparam logic [14:0] OFF_EVENT    = 15'h2004;
	localparam logic [14:0] OFF_IPI_SEND = 15'h2008;
	localparam logic [14:0] OFF_IPI_ACK  = 15'h200c;
	localparam logic [14:0] OFF_IPI_MSET = 15'h2024;
	localparam logic [14:0] OFF_IPI_MCLR = 15'h2028;
	localparam logic [14:0] OFF_TARGET   = 15'h3000;
	localparam logic [14:0] OFF_BANK     = 15'h4000;
	localparam logic [14:0] OFF_BANK_END = 15'h4200;

	// bank selects within the bank region
	localparam logic [1:0] BANK_SW_SET   = 2'd0;
	localparam logic [1:0] BANK_SW_CLR   = 2'd1;
	localparam logic [1:0] BANK_MASK_SET = 2'd2;
	localparam logic [1:0] BANK_MASK_CLR = 2'd3;

	// event word types and IPI numbers
	localparam logic [15:0] EVT_HW    = 16'd1;
	localparam logic [15:0] EVT_IPI   = 16'd4;
	localparam logic [15:0] IPI_OTHER = 16'd1;
	localparam logic [15:0] IPI_SELF  = 16'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SCAN,
		ST_FINISH,
		ST_REPORT
	} pic_state_t;

	typedef struct packed {
		logic cap_en;
		logic access_en;
		logic scan_en;
		logic finish_en;
		logic out_load;
	} pic_cmd_t;

	typedef struct packed {
		logic scan_last;
	} pic_status_t;

endpackage

// ----- src/pic_ctrl.sv -----
// Sequencer of the interrupt controller: handshakes and step order.
// Depends on pic_pkg; drives pic_datapath through pic_cmd_t.
module pic_ctrl import pic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output pic_cmd_t    cmd,
	input  pic_status_t status
);

	pic_state_t state_q, state_next;
	logic out_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_en = 1'b1;
					state_next = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access_en = 1'b1;
				state_next = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (status.scan_last)
					state_next = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish_en = 1'b1;
				state_next = ST_REPORT;
			end
			ST_REPORT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/pic_datapath.sv -----
// Register file, access decode and word scan of the interrupt controller.
// Depends on pic_pkg; commanded by pic_ctrl.
module pic_datapath import pic_pkg::*; #(
	parameter int NUM_IRQ = PIC_NUM_IRQ,
	parameter int NUM_CPU = PIC_NUM_CPU
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pic_cmd_t    cmd,
	output pic_status_t status,
	input  logic [1:0]  req_type,
	input  logic [2:0]  cpu_index,
	input  logic [14:0] reg_offset,
	input  logic [31:0] write_data,
	input  logic [9:0]  line_number,
	input  logic        line_level,
	output logic [31:0] read_data,
	output logic [7:0]  irq_request,
	output logic        access_error
);

	localparam int NW = (NUM_IRQ + 31) / 32;
	localparam int WW = (NW > 1) ? $clog2(NW) : 1;
	localparam int NC = (NUM_CPU < 8) ? NUM_CPU : 8;
	localparam int CW = (NC > 1) ? $clog2(NC) : 1;
	localparam int LAST_BITS = NUM_IRQ - 32 * (NW - 1);
	localparam logic [31:0] LAST_MASK = 32'hffff_ffff >> (32 - LAST_BITS);
	localparam logic [16:0] TGT_END = 17'(32'(OFF_TARGET) + 4 * NUM_IRQ);

	// one-hot word to bit number
	function automatic logic [4:0] onehot_enc(input logic [31:0] v);
		logic [4:0] e;
		e = '0;
		for (int b = 0; b < 32; b++)
			if (v[b])
				e = e | 5'(b);
		return e;
	endfunction

	function automatic logic [31:0] write_data_masked(input logic [31:0] d,
		input logic [31:0] m);
		return d & m;
	endfunction

	// captured request
	logic [1:0]  req_q;
	logic [2:0]  cpu_q;
	logic [14:0] off_q;
	logic [31:0] data_q;
	logic [9:0]  line_q;
	logic        lvl_in_q;

	// state, in 32-bit words; targets kept as one bit plane per CPU
	logic [31:0] lvl_q  [NW];
	logic [31:0] soft_q [NW];
	logic [31:0] mask_q [NW];
	logic [31:0] tgt_q  [NC][NW];
	logic [1:0]  pend_q [NC];
	logic [1:0]  imask_q [NC];

	// per item work registers
	logic [WW-1:0] ptr_q;
	logic          evt_q;
	logic          found_q;
	logic [NC-1:0] reqhw_q;
	logic [31:0]   rd_q;
	logic          err_q;

	// output register
	logic [31:0] read_data_q;
	logic [7:0]  irq_request_q;
	logic        access_error_q;
	logic [7:0]  irq_next;

	// decode
	logic          is_bus, wr, aligned, cpu_ok;
	logic          hit_event, hit_ipi, hit_tgt, hit_bank, known;
	logic [CW-1:0] ci;
	logic [9:0]    tn;
	logic [WW-1:0] tw, bw, lw;
	logic [4:0]    tb;
	logic [1:0]    bsel;
	logic [31:0]   bvm, acc_rd, bwd;

	assign is_bus = (req_q == REQ_READ) || (req_q == REQ_WRITE);
	assign wr = req_q == REQ_WRITE;
	assign aligned = off_q[1:0] == 2'b00;
	assign cpu_ok = 32'(cpu_q) < NUM_CPU;
	assign ci = CW'(cpu_q);
	assign hit_event = off_q == OFF_EVENT;
	assign hit_ipi = (off_q == OFF_IPI_SEND) || (off_q == OFF_IPI_ACK) ||
		(off_q == OFF_IPI_MSET) || (off_q == OFF_IPI_MCLR);
	assign hit_tgt = (off_q >= OFF_TARGET) && ({2'b00, off_q} < TGT_END);
	assign hit_bank = (off_q >= OFF_BANK) && (off_q < OFF_BANK_END) &&
		(32'(off_q[6:2]) < NW);
	assign known = hit_event || hit_ipi || hit_tgt || hit_bank;
	assign tn = off_q[11:2];
	assign tw = WW'(tn[9:5]);
	assign tb = tn[4:0];
	assign bw = WW'(off_q[6:2]);
	assign bsel = off_q[8:7];
	assign lw = WW'(line_q[9:5]);
	assign bvm = (32'(bw) == NW - 1) ? LAST_MASK : 32'hffff_ffff;
	assign bwd = write_data_masked(data_q, bvm);

	// read data of a plain register access
	always_comb begin
		acc_rd = '0;
		if (hit_ipi && cpu_ok) begin
			if (off_q == OFF_IPI_MSET || off_q == OFF_IPI_MCLR)
				acc_rd = {imask_q[ci][1], 30'b0, imask_q[ci][0]};
			else
				acc_rd = {pend_q[ci][1], 30'b0, pend_q[ci][0]};
		end else if (hit_tgt) begin
			for (int c = 0; c < NC; c++)
				acc_rd[c] = tgt_q[c][tw][tb];
		end else if (hit_bank) begin
			if (bsel == BANK_SW_SET || bsel == BANK_SW_CLR)
				acc_rd = soft_q[bw] & bvm;
			else
				acc_rd = mask_q[bw] & bvm;
		end
	end

	// scan of one word
	logic [31:0] eff, hk, one, effa;
	logic        take;

	always_comb begin
		eff = (lvl_q[ptr_q] | soft_q[ptr_q]) & ~mask_q[ptr_q];
		hk = eff & tgt_q[ci][ptr_q];
		take = evt_q && !found_q && (hk != '0);
		one = hk & (~hk + 32'd1);
		effa = take ? (eff & ~one) : eff;
	end

	assign status.scan_last = 32'(ptr_q) == NW - 1;

	// capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			req_q <= req_type;
			cpu_q <= cpu_index;
			off_q <= reg_offset;
			data_q <= write_data;
			line_q <= line_number;
			lvl_in_q <= line_level;
		end
	end

	// state registers and per item work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NW; w++) begin
				lvl_q[w] <= '0;
				soft_q[w] <= '0;
				mask_q[w] <= '1;
				for (int c = 0; c < NC; c++)
					tgt_q[c][w] <= (c == 0) ? '1 : '0;
			end
			for (int c = 0; c < NC; c++) begin
				pend_q[c] <= '0;
				imask_q[c] <= '1;
			end
			ptr_q <= '0;
			evt_q <= 1'b0;
			found_q <= 1'b0;
			reqhw_q <= '0;
			rd_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (cmd.cap_en) begin
				ptr_q <= '0;
				found_q <= 1'b0;
				reqhw_q <= '0;
				evt_q <= 1'b0;
			end
			// apply the access
			if (cmd.access_en) begin
				rd_q <= (is_bus && aligned && !hit_event && !wr) ? acc_rd : '0;
				err_q <= is_bus && (!aligned || !known);
				if (req_q == REQ_LINE) begin
					if (32'(line_q) < NUM_IRQ)
						lvl_q[lw][line_q[4:0]] <= lvl_in_q;
				end else if (is_bus && aligned) begin
					if (hit_event) begin
						evt_q <= !wr && cpu_ok;
					end else if (wr && hit_ipi) begin
						if (cpu_ok) begin
							case (off_q)
								OFF_IPI_SEND: begin
									for (int c = 0; c < NC; c++)
										if (data_q[c])
											pend_q[c][0] <= 1'b1;
									if (data_q[31])
										pend_q[ci][1] <= 1'b1;
								end
								OFF_IPI_ACK:
									pend_q[ci] <= pend_q[ci] & ~{data_q[31], data_q[0]};
								OFF_IPI_MSET:
									imask_q[ci] <= imask_q[ci] | {data_q[31], data_q[0]};
								default:
									imask_q[ci] <= imask_q[ci] & ~{data_q[31], data_q[0]};
							endcase
						end
					end else if (wr && hit_tgt) begin
						for (int c = 0; c < NC; c++)
							tgt_q[c][tw][tb] <= data_q[c];
					end else if (wr && hit_bank) begin
						case (bsel)
							BANK_SW_SET:   soft_q[bw] <= soft_q[bw] | bwd;
							BANK_SW_CLR:   soft_q[bw] <= soft_q[bw] & ~bwd;
							BANK_MASK_SET: mask_q[bw] <= mask_q[bw] | bwd;
							default:       mask_q[bw] <= mask_q[bw] & ~bwd;
						endcase
					end
				end
			end
			// advance the scan one word, delivering the first hit
			if (cmd.scan_en) begin
				if (!status.scan_last)
					ptr_q <= ptr_q + WW'(1);
				if (take) begin
					mask_q[ptr_q] <= mask_q[ptr_q] | one;
					found_q <= 1'b1;
					rd_q <= {EVT_HW, 16'({ptr_q, onehot_enc(one)})};
				end
				for (int c = 0; c < NC; c++)
					if ((effa & tgt_q[c][ptr_q]) != '0)
						reqhw_q[c] <= 1'b1;
			end
			// fall back to the IPIs
			if (cmd.finish_en && evt_q && !found_q) begin
				if (pend_q[ci][0] && !imask_q[ci][0]) begin
					imask_q[ci][0] <= 1'b1;
					rd_q <= {EVT_IPI, IPI_OTHER};
				end else if (pend_q[ci][1] && !imask_q[ci][1]) begin
					imask_q[ci][1] <= 1'b1;
					rd_q <= {EVT_IPI, IPI_SELF};
				end
			end
		end
	end

	// per-CPU request vector after the item
	always_comb begin
		irq_next = '0;
		for (int c = 0; c < NC; c++)
			irq_next[c] = reqhw_q[c] || ((pend_q[c] & ~imask_q[c]) != 2'b00);
	end

	// load the result beat
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data_q <= rd_q;
			access_error_q <= err_q;
			irq_request_q <= irq_next;
		end
	end

	assign read_data = read_data_q;
	assign irq_request = irq_request_q;
	assign access_error = access_error_q;

endmodule

// ----- src/prioritized_interrupt_controller_top.sv -----
// Top level of the prioritized interrupt controller.
// Depends on pic_pkg, pic_ctrl and pic_datapath.
//
// Usage: one request beat on the input channel (bus read, bus write or a
// hardware line level update) gives exactly one result beat on the output
// channel: read data, the per-CPU interrupt request vector after the request
// and an access error flag for unknown or misaligned offsets.
// After the accepting edge the block steps through the register access, the
// scan over the pending/mask/target words (one word per cycle, NW words with
// NW = ceil(NUM_IRQ / 32), 28 at the default NUM_IRQ = 896), the fall back to
// IPIs and the load of the result. A new beat is taken only in the idle state,
// so one beat is in flight at a time.
// An event read masks what it delivers: a hardware source during the scan, an IPI in the fallback step.
// Reset clears all levels, software and IPI pending bits, masks every source
// and targets every interrupt at CPU 0; the block is ready right after reset.
// When the receiver stalls, the result waits in the output register; a
// following request may be accepted and runs up to its own result, then
// holds until the previous result is taken.
module prioritized_interrupt_controller_top import pic_pkg::*; #(
	parameter int NUM_IRQ = PIC_NUM_IRQ,
	parameter int NUM_CPU = PIC_NUM_CPU
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [2:0]  cpu_index,
	input  logic [14:0] reg_offset,
	input  logic [31:0] write_data,
	input  logic [9:0]  line_number,
	input  logic        line_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [7:0]  irq_request,
	output logic        access_error
);

	pic_cmd_t    cmd;
	pic_status_t status;

	pic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	pic_datapath #(
		.NUM_IRQ (NUM_IRQ),
		.NUM_CPU (NUM_CPU)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.cpu_index    (cpu_index),
		.reg_offset   (reg_offset),
		.write_data   (write_data),
		.line_number  (line_number),
		.line_level   (line_level),
		.read_data    (read_data),
		.irq_request  (irq_request),
		.access_error (access_error)
	);

endmodule
